>>> rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	`CHK_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/fnv_pkg.sv
// Package for the FNV byte-stream hash: constants, codes and the fold function.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package fnv_pkg;

	localparam int HASH_W     = 64;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [HASH_W-1:0] BASIS32 = 64'd2166136261;
	localparam logic [HASH_W-1:0] PRIME32 = 64'd16777619;
	localparam logic [HASH_W-1:0] BASIS64 = 64'hCBF2_9CE4_8422_2325;
	localparam logic [HASH_W-1:0] PRIME64 = 64'h0000_0100_0000_01B3;
	localparam logic [HASH_W-1:0] MASK32  = 64'h0000_0000_FFFF_FFFF;

	// Combining rule
	typedef enum logic [1:0] {
		VAR_FNV1    = 2'd0,
		VAR_FNV1A   = 2'd1,
		VAR_MUL_ADD = 2'd2,
		VAR_ADD_MUL = 2'd3
	} variant_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VARIANT   = 2'd0,
		REG_WIDE_MODE = 2'd1
	} cfg_reg_t;

	function automatic logic [HASH_W-1:0] start_value(input logic wide);
		return wide ? BASIS64 : BASIS32;
	endfunction

	// Multiply by the prime as a shift-add; both primes are sparse.
	// PRIME64 = 2^40 + 0x1B3, PRIME32 = 2^24 + 0x193.
	function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h,
			input logic wide);
		logic [HASH_W-1:0] p64;
		logic [HASH_W-1:0] p32;
		p64 = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
		p32 = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
		return wide ? p64 : p32;
	endfunction

	// One byte folded into the hash, wrapped to the selected width
	function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] b, input variant_t v, input logic wide);
		logic [HASH_W-1:0] bx;
		logic [HASH_W-1:0] r;
		bx = {{(HASH_W-BYTE_W){1'b0}}, b};
		case (v)
			VAR_FNV1:    r = mul_prime(h, wide) ^ bx;
			VAR_FNV1A:   r = mul_prime(h ^ bx, wide);
			VAR_MUL_ADD: r = mul_prime(h, wide) + bx;
			VAR_ADD_MUL: r = mul_prime(h + bx, wide);
			default:     r = h;
		endcase
		return wide ? r : (r & MASK32);
	endfunction

endpackage

>>> rtl/fnv_ifs.sv
// Channel interfaces of the FNV hash: message bytes, digests, register writes.
// Depends on fnv_pkg for field widths.
`timescale 1ns / 1ps

interface fnv_in_if;
	import fnv_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              byte_valid;
	logic              last;
	modport source (output valid, data_byte, byte_valid, last, input ready);
	modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface fnv_out_if;
	import fnv_pkg::*;
	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] hash_value;
	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

interface fnv_cfg_if;
	import fnv_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

>>> rtl/fnv_hash_byte_stream.sv
// FNV-1 / FNV-1a / additive byte-stream hash, 32 or 64 bit, one byte per cycle
// unless a last-marked byte waits on a stalled digest. A last-marked item's digest
// passes the input stage register, then the digest register; a stalled digest can hold it.
// Throughput: one item per cycle while no last item waits on a stalled digest; set by
// the hash feedback through the combinational shift-add prime multiply and combine.
// Reset (arst_n low, asynchronous): variant FNV-1a, 32-bit mode, hash at the
// 32-bit offset basis, input stage and digest register empty.
`timescale 1ns / 1ps

module fnv_hash_byte_stream (
	input logic        clk,
	input logic        arst_n,
	fnv_in_if.sink     msg,
	fnv_out_if.source  digest,
	fnv_cfg_if.sink    cfg
);
	import fnv_pkg::*;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              byte_valid_s1;
	logic              last_s1;

	// Configuration and running state
	variant_t          variant_q;
	logic              wide_mode_q;
	logic [HASH_W-1:0] hash_q;

	// Digest register
	logic              out_valid_q;
	logic [HASH_W-1:0] hash_out_q;

	logic              advance;
	logic [HASH_W-1:0] folded;
	logic              cfg_hit;
	logic              wide_next;

	// The stage moves on unless it holds a last item facing a full, stalled digest
	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || digest.ready);
	assign msg.ready = !valid_s1 || advance;

	assign folded = byte_valid_s1 ?
		fold_byte(hash_q, data_byte_s1, variant_q, wide_mode_q) : hash_q;

	assign cfg.ready         = 1'b1;
	assign digest.valid      = out_valid_q;
	assign digest.hash_value = hash_out_q;

	// Decode a register write; unknown indexes leave everything alone
	always_comb begin
		cfg_hit   = 1'b0;
		wide_next = wide_mode_q;
		case (cfg_reg_t'(cfg.index))
			REG_VARIANT: begin
				cfg_hit = cfg.valid;
			end
			REG_WIDE_MODE: begin
				cfg_hit = cfg.valid;
				wide_next = cfg.wdata[0];
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_byte_s1  <= msg.data_byte;
			byte_valid_s1 <= msg.byte_valid;
			last_s1       <= msg.last;
		end
	end

	// Registers and running hash; a register write restarts the hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q   <= VAR_FNV1A;
			wide_mode_q <= 1'b0;
			hash_q      <= BASIS32;
		end else if (cfg_hit) begin
			if (cfg_reg_t'(cfg.index) == REG_VARIANT) begin
				variant_q <= variant_t'(cfg.wdata);
			end
			wide_mode_q <= wide_next;
			hash_q      <= start_value(wide_next);
		end else if (advance) begin
			hash_q <= last_s1 ? start_value(wide_mode_q) : folded;
		end
	end

	// Digest valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (digest.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Digest payload
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			hash_out_q <= folded;
		end
	end

endmodule

>>> rtl/fnv_chk.sv
// Port-level checker for fnv_hash_byte_stream, attached by bind.
// Depends on fnv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fnv_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          msg_valid,
	input logic                          msg_ready,
	input logic                          dig_valid,
	input logic                          dig_ready,
	input logic [fnv_pkg::HASH_W-1:0]    dig_hash,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [fnv_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fnv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fnv_pkg::*;

	logic wide_q;

	// Track the width mode from register write transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_valid && cfg_ready && cfg_index == REG_WIDE_MODE) begin
			wide_q <= cfg_wdata[0];
		end
	end

	// A stalled digest holds
	`CHK_ASSERT(a_digest_hold, (dig_valid && !dig_ready) |=> (dig_valid && $stable(dig_hash)), "digest changed while stalled")

	// In 32-bit mode the digest's upper half is zero
	`CHK_IMPLY(a_upper_zero, dig_valid && !wide_q, dig_hash[HASH_W-1:32] == 32'd0, "upper digest bits set in 32-bit mode")

	// Input backpressure only comes from a stalled digest
	`CHK_IMPLY(a_bp_cause, !msg_ready, dig_valid && !dig_ready, "input stalled without a stalled digest")

	// Register writes are never refused
	`CHK_IMPLY(a_cfg_ready, cfg_valid, cfg_ready, "register write refused")

endmodule

bind fnv_hash_byte_stream fnv_chk u_fnv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg.valid),
	.msg_ready (msg.ready),
	.dig_valid (digest.valid),
	.dig_ready (digest.ready),
	.dig_hash  (digest.hash_value),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.cfg_index (cfg.index),
	.cfg_wdata (cfg.wdata)
);
